// File: sv/sprite_sheet_frame_sequencer_defines.svh
// Assertion helpers shared by the sprite sheet frame sequencer.
// Every check is clocked on clk and switched off while rst is high.
`ifndef SPRITE_SHEET_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_SHEET_FRAME_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ssfs_pkg.sv
package ssfs_pkg;

  // Field widths of the stream payloads.
  localparam int TICKS_W = 16;
  localparam int FRAME_W = 10;
  localparam int COORD_W = 17;
  localparam int SIZE_W  = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PLAY_MODE      = 3'd0,
    CFG_FRAME_DURATION = 3'd1,
    CFG_START_FRAME    = 3'd2,
    CFG_FRAME_COUNT    = 3'd3,
    CFG_COLUMN_COUNT   = 3'd4,
    CFG_ROW_COUNT      = 3'd5,
    CFG_SHEET_ORIGIN   = 3'd6,
    CFG_SHEET_SIZE     = 3'd7
  } cfg_idx_t;

  // Play modes.
  typedef enum logic [1:0] {
    MODE_CLAMP_FWD = 2'd0,
    MODE_LOOP_FWD  = 2'd1,
    MODE_CLAMP_BWD = 2'd2,
    MODE_LOOP_BWD  = 2'd3
  } mode_t;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_IDLE,      // take a request
    OP_TICK,      // subtract elapsed ticks, start the skip division
    OP_DIV,       // one restoring division step
    OP_SKIP,      // new time left and saturated skip count
    OP_FRAME,     // move the current frame
    OP_START_FW,  // start sheet width / columns
    OP_START_FH,  // keep frame width, start sheet height / rows
    OP_START_RC,  // keep frame height, start frame / columns
    OP_MUL,       // column and row offsets
    OP_EMIT,      // load the result register
    OP_NOP
  } op_t;

  // Jump conditions; a false condition falls through to the next step.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_NO_BOUNDARY,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Program step addresses.
  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_TICK     = 4'd1;
  localparam step_t ST_DIV_TIME = 4'd2;
  localparam step_t ST_SKIP     = 4'd3;
  localparam step_t ST_FRAME    = 4'd4;
  localparam step_t ST_START_FW = 4'd5;
  localparam step_t ST_DIV_FW   = 4'd6;
  localparam step_t ST_START_FH = 4'd7;
  localparam step_t ST_DIV_FH   = 4'd8;
  localparam step_t ST_START_RC = 4'd9;
  localparam step_t ST_DIV_RC   = 4'd10;
  localparam step_t ST_MUL      = 4'd11;
  localparam step_t ST_EMIT     = 4'd12;
  localparam step_t ST_RETURN   = 4'd13;

  // Control store. Unused addresses park the sequencer back at idle.
  function automatic uword_t ucode_rom(step_t addr);
    uword_t w;
    unique case (addr)
      ST_IDLE:     w = '{OP_IDLE,     COND_NO_REQ,      ST_IDLE};
      ST_TICK:     w = '{OP_TICK,     COND_NO_BOUNDARY, ST_START_FW};
      ST_DIV_TIME: w = '{OP_DIV,      COND_DIV_MORE,    ST_DIV_TIME};
      ST_SKIP:     w = '{OP_SKIP,     COND_NEVER,       ST_IDLE};
      ST_FRAME:    w = '{OP_FRAME,    COND_NEVER,       ST_IDLE};
      ST_START_FW: w = '{OP_START_FW, COND_NEVER,       ST_IDLE};
      ST_DIV_FW:   w = '{OP_DIV,      COND_DIV_MORE,    ST_DIV_FW};
      ST_START_FH: w = '{OP_START_FH, COND_NEVER,       ST_IDLE};
      ST_DIV_FH:   w = '{OP_DIV,      COND_DIV_MORE,    ST_DIV_FH};
      ST_START_RC: w = '{OP_START_RC, COND_NEVER,       ST_IDLE};
      ST_DIV_RC:   w = '{OP_DIV,      COND_DIV_MORE,    ST_DIV_RC};
      ST_MUL:      w = '{OP_MUL,      COND_NEVER,       ST_IDLE};
      ST_EMIT:     w = '{OP_EMIT,     COND_OUT_BUSY,    ST_EMIT};
      ST_RETURN:   w = '{OP_NOP,      COND_ALWAYS,      ST_IDLE};
      default:     w = '{OP_NOP,      COND_ALWAYS,      ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: sv/sprite_sheet_frame_sequencer.sv
// Sprite sheet frame sequencer. Each request on the input stream carries the
// ticks elapsed since the previous one; the block counts down the time left in
// the shown frame, steps the frame by the number of boundaries passed in the
// configured play mode, and returns one result with the frame's rectangle in
// the sheet. Control is a microprogram of fourteen steps driving one 16-bit
// restoring divider, which sets the rate: a request is done, and the next one
// taken, only after its divisions have run (one extra division when a frame
// boundary passes) and its result has been loaded into the output register,
// which waits while the previous result is still held there. Results leave
// through that register, so the next request is taken while one waits.
// Configuration writes are always accepted and must be made while idle.
`include "sprite_sheet_frame_sequencer_defines.svh"

module sprite_sheet_frame_sequencer
  import ssfs_pkg::*;
#(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  // Input stream. tdata: elapsed_ticks[15:0].
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Output stream. tdata: rect_x[16:0], rect_y[33:17], frame_width[49:34],
  // frame_height[65:50], shown_frame[75:66], frame_advanced[76], zeros[79:77].
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int SKIP_W = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W  = ((SKIP_W > 12) ? SKIP_W : 12) + 2;
  localparam logic [FRAME_W-1:0] LAST_LIMIT =
    FRAME_W'((MAX_FRAMES - 1 > 1023) ? 1023 : MAX_FRAMES - 1);
  localparam logic [16:0] SKIP_MAX = 17'(MAX_FRAMES);

  // Configuration registers.
  mode_t        play_mode;
  logic [15:0]  frame_duration;
  logic [9:0]   start_frame;
  logic [10:0]  frame_count;
  logic [8:0]   column_count;
  logic [8:0]   row_count;
  logic [31:0]  sheet_origin;
  logic [31:0]  sheet_size;

  // Sequencer and datapath registers.
  step_t               step;
  step_t               step_next;
  uword_t              ucw;
  logic                cond_true;
  logic [TICKS_W-1:0]  ticks;
  logic [TICKS_W-1:0]  time_left;
  logic [FRAME_W-1:0]  cur_frame;
  logic [SKIP_W-1:0]   skip;
  logic                advanced;
  logic [SIZE_W-1:0]   fw;
  logic [SIZE_W-1:0]   fh;
  logic [COORD_W-1:0]  prod_x;
  logic [COORD_W-1:0]  prod_y;
  logic [15:0]         div_rem;
  logic [15:0]         div_quo;
  logic [15:0]         div_den;
  logic [3:0]          div_cnt;

  // Output register.
  logic                out_valid;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic [SIZE_W-1:0]   out_fw;
  logic [SIZE_W-1:0]   out_fh;
  logic [FRAME_W-1:0]  out_frame;
  logic                out_adv;
  logic                out_busy;

  // Zero counts and durations behave as one.
  logic [15:0] dur_n;
  logic [10:0] cnt_n;
  logic [8:0]  cols_n;
  logic [8:0]  rows_n;
  assign dur_n  = (frame_duration == '0) ? 16'd1 : frame_duration;
  assign cnt_n  = (frame_count == '0) ? 11'd1 : frame_count;
  assign cols_n = (column_count == '0) ? 9'd1 : column_count;
  assign rows_n = (row_count == '0) ? 9'd1 : row_count;

  // Last frame of the sequence, saturated to the frame index range.
  logic [11:0]        last_raw;
  logic [FRAME_W-1:0] last_frame;
  assign last_raw   = {2'b00, start_frame} + {1'b0, cnt_n} - 12'd1;
  assign last_frame = (last_raw > {2'b00, LAST_LIMIT}) ? LAST_LIMIT : last_raw[FRAME_W-1:0];

  // Elapsed ticks reach or pass the time left: at least one boundary.
  logic boundary;
  assign boundary = (time_left <= ticks);

  // One restoring division step.
  logic [17:0] div_trial;
  logic        div_neg;
  assign div_trial = {1'b0, div_rem, div_quo[15]} - {2'b00, div_den};
  assign div_neg   = div_trial[17];

  // Skip count: boundaries passed, saturated.
  logic [16:0]       skip_full;
  logic [SKIP_W-1:0] skip_next;
  assign skip_full = {1'b0, div_quo} + 17'd1;
  assign skip_next = (skip_full > SKIP_MAX) ? SKIP_MAX[SKIP_W-1:0] : skip_full[SKIP_W-1:0];

  // Frame movement in each play mode.
  logic signed [SUM_W-1:0] fwd_sum;
  logic signed [SUM_W-1:0] bwd_sum;
  logic signed [SUM_W-1:0] first_ext;
  logic signed [SUM_W-1:0] last_ext;
  logic [FRAME_W-1:0]      frame_next;
  assign fwd_sum   = $signed({{(SUM_W-FRAME_W){1'b0}}, cur_frame})
                   + $signed({{(SUM_W-SKIP_W){1'b0}}, skip});
  assign bwd_sum   = $signed({{(SUM_W-FRAME_W){1'b0}}, cur_frame})
                   - $signed({{(SUM_W-SKIP_W){1'b0}}, skip});
  assign first_ext = $signed({{(SUM_W-FRAME_W){1'b0}}, start_frame});
  assign last_ext  = $signed({{(SUM_W-FRAME_W){1'b0}}, last_frame});

  always_comb begin
    unique case (play_mode)
      MODE_CLAMP_FWD: frame_next = (fwd_sum > last_ext) ? last_frame : fwd_sum[FRAME_W-1:0];
      MODE_LOOP_FWD:  frame_next = (fwd_sum > last_ext) ? start_frame : fwd_sum[FRAME_W-1:0];
      MODE_CLAMP_BWD: frame_next = (bwd_sum < first_ext) ? start_frame : bwd_sum[FRAME_W-1:0];
      MODE_LOOP_BWD:  frame_next = (bwd_sum < first_ext) ? last_frame : bwd_sum[FRAME_W-1:0];
      default:        frame_next = cur_frame;
    endcase
  end

  // Offsets of the frame's column and row; the divider holds the column in
  // its remainder and the row in its quotient at this point. A column count
  // above 256 leaves columns that need all nine remainder bits.
  logic [24:0] mul_x;
  logic [25:0] mul_y;
  assign mul_x = {16'b0, div_rem[8:0]} * {9'b0, fw};
  assign mul_y = {16'b0, div_quo[9:0]} * {10'b0, fh};

  assign out_busy = out_valid && !m_axis_tready;

  // Control word decode and handshake outputs.
  always_comb begin
    ucw = ucode_rom(step);
    unique case (ucw.cond)
      COND_NEVER:       cond_true = 1'b0;
      COND_ALWAYS:      cond_true = 1'b1;
      COND_NO_REQ:      cond_true = !s_axis_tvalid;
      COND_NO_BOUNDARY: cond_true = !boundary;
      COND_DIV_MORE:    cond_true = (div_cnt != '0);
      COND_OUT_BUSY:    cond_true = out_busy;
      default:          cond_true = 1'b0;
    endcase
    s_axis_tready = (ucw.op == OP_IDLE);
  end

  // Step counter: jump on a true condition, else fall through.
  always_comb begin
    if (cond_true) begin
      step_next = ucw.target;
    end else begin
      step_next = step + 4'd1;
    end
  end

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode      <= MODE_LOOP_FWD;
      frame_duration <= 16'd1;
      start_frame    <= '0;
      frame_count    <= 11'd1;
      column_count   <= 9'd1;
      row_count      <= 9'd1;
      sheet_origin   <= '0;
      sheet_size     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PLAY_MODE:      play_mode      <= mode_t'(cfg_data[1:0]);
        CFG_FRAME_DURATION: frame_duration <= cfg_data[15:0];
        CFG_START_FRAME:    start_frame    <= cfg_data[9:0];
        CFG_FRAME_COUNT:    frame_count    <= cfg_data[10:0];
        CFG_COLUMN_COUNT:   column_count   <= cfg_data[8:0];
        CFG_ROW_COUNT:      row_count      <= cfg_data[8:0];
        CFG_SHEET_ORIGIN:   sheet_origin   <= cfg_data;
        CFG_SHEET_SIZE:     sheet_size     <= cfg_data;
        default:            play_mode      <= play_mode;
      endcase
    end
  end

  // Sequencer state, frame state and divider control.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      time_left <= '0;
      cur_frame <= '0;
      div_cnt   <= '0;
    end else begin
      step <= step_next;
      unique case (ucw.op)
        OP_TICK: begin
          if (!boundary) begin
            time_left <= time_left - ticks;
          end else begin
            div_cnt <= 4'd15;
          end
        end
        OP_DIV: begin
          if (div_cnt != '0) begin
            div_cnt <= div_cnt - 4'd1;
          end
        end
        OP_SKIP:     time_left <= dur_n - div_rem;
        OP_FRAME:    cur_frame <= frame_next;
        OP_START_FW: div_cnt   <= 4'd15;
        OP_START_FH: div_cnt   <= 4'd15;
        OP_START_RC: div_cnt   <= 4'd15;
        default:     div_cnt   <= div_cnt;
      endcase
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    unique case (ucw.op)
      OP_IDLE: begin
        if (s_axis_tvalid) begin
          ticks <= s_axis_tdata[TICKS_W-1:0];
        end
      end
      OP_TICK: begin
        advanced <= boundary;
        div_rem  <= '0;
        div_quo  <= ticks - time_left;
        div_den  <= dur_n;
      end
      OP_DIV: begin
        div_rem <= div_neg ? {div_rem[14:0], div_quo[15]} : div_trial[15:0];
        div_quo <= {div_quo[14:0], !div_neg};
      end
      OP_SKIP: skip <= skip_next;
      OP_START_FW: begin
        div_rem <= '0;
        div_quo <= sheet_size[15:0];
        div_den <= {7'b0, cols_n};
      end
      OP_START_FH: begin
        fw      <= div_quo;
        div_rem <= '0;
        div_quo <= sheet_size[31:16];
        div_den <= {7'b0, rows_n};
      end
      OP_START_RC: begin
        fh      <= div_quo;
        div_rem <= '0;
        div_quo <= {6'b0, cur_frame};
        div_den <= {7'b0, cols_n};
      end
      OP_MUL: begin
        prod_x <= mul_x[COORD_W-1:0];
        prod_y <= mul_y[COORD_W-1:0];
      end
      default: ticks <= ticks;
    endcase
  end

  // Output register: loaded once the previous result has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ucw.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ucw.op == OP_EMIT && !out_busy) begin
      out_x     <= {1'b0, sheet_origin[15:0]} + prod_x;
      out_y     <= {1'b0, sheet_origin[31:16]} + prod_y;
      out_fw    <= fw;
      out_fh    <= fh;
      out_frame <= cur_frame;
      out_adv   <= advanced;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_adv, out_frame, out_fh, out_fw, out_y, out_x};

  // After a boundary the time left lands within one frame duration.
  `SSFS_ASSERT_NEXT(a_time_after_boundary, ucw.op == OP_SKIP,
    time_left != '0 && time_left <= $past(dur_n), "time left outside one frame duration")
  // A division loop leaves its step once the last bit is done.
  `SSFS_ASSERT_NEXT(a_div_exits, ucw.op == OP_DIV && div_cnt == '0,
    step != $past(step), "division loop did not terminate")
  // The shown frame only moves in the frame update step.
  `SSFS_ASSERT_SAME(a_frame_moves, !$past(rst) && !$stable(cur_frame),
    $past(ucw.op == OP_FRAME), "current frame changed outside its update step")
  // A request is only taken with the divider at rest.
  `SSFS_ASSERT_SAME(a_idle_divider, s_axis_tvalid && s_axis_tready,
    div_cnt == '0, "request taken while a division runs")

endmodule

// File: sim/sprite_sheet_frame_sequencer_test.sv
module sprite_sheet_frame_sequencer_test;
  import ssfs_pkg::*;

  // One result of the block, unpacked from the output stream.
  typedef struct packed {
    logic [16:0] rect_x;
    logic [16:0] rect_y;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [9:0]  shown_frame;
    logic        frame_advanced;
  } frame_rect_t;

  // One line of the directed plan: a register write or a request.
  typedef struct {
    bit          is_write;
    cfg_idx_t    index;
    logic [31:0] data;
    bit          has_want;
    frame_rect_t want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [31:0]           cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the registers and of the animation state.
  mode_t       play_mode_q;
  logic [15:0] frame_duration_q;
  logic [9:0]  start_frame_q;
  logic [10:0] frame_count_q;
  logic [8:0]  column_count_q;
  logic [8:0]  row_count_q;
  logic [31:0] sheet_origin_q;
  logic [31:0] sheet_size_q;
  logic [31:0] ticks_left_q;
  logic [9:0]  frame_q;

  frame_rect_t pending_frames[$];
  plan_row_t   plan[$];
  int unsigned mismatch_count = 0;
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned stall_left = 0;

  sprite_sheet_frame_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The run must end well before this; reaching it means the block hung.
  initial begin
    #1000000;
    $display("sprite_sheet_frame_sequencer_test: errors");
    $finish;
  end

  // Put the shadow registers and state back to their reset values.
  function automatic void reset_shadow();
    play_mode_q      = MODE_LOOP_FWD;
    frame_duration_q = 16'd1;
    start_frame_q    = '0;
    frame_count_q    = 11'd1;
    column_count_q   = 9'd1;
    row_count_q      = 9'd1;
    sheet_origin_q   = '0;
    sheet_size_q     = '0;
    ticks_left_q     = '0;
    frame_q          = '0;
  endfunction

  // Mirror one accepted register write.
  function automatic void apply_write(cfg_idx_t index, logic [31:0] data);
    case (index)
      CFG_PLAY_MODE:      play_mode_q = mode_t'(data[1:0]);
      CFG_FRAME_DURATION: frame_duration_q = data[15:0];
      CFG_START_FRAME:    start_frame_q = data[9:0];
      CFG_FRAME_COUNT:    frame_count_q = data[10:0];
      CFG_COLUMN_COUNT:   column_count_q = data[8:0];
      CFG_ROW_COUNT:      row_count_q = data[8:0];
      CFG_SHEET_ORIGIN:   sheet_origin_q = data;
      CFG_SHEET_SIZE:     sheet_size_q = data;
      default: ;
    endcase
  endfunction

  // Advance the animation by one step of elapsed ticks and build the
  // rectangle of the frame shown afterwards.
  function automatic frame_rect_t step_frame(logic [15:0] ticks);
    longint duration, span, cols, rows, first, last;
    longint remaining, passed, skip, frame;
    longint width, height;
    bit boundary;
    frame_rect_t r;
    duration = (frame_duration_q == 0) ? 1 : longint'(frame_duration_q);
    span     = (frame_count_q == 0) ? 1 : longint'(frame_count_q);
    cols     = (column_count_q == 0) ? 1 : longint'(column_count_q);
    rows     = (row_count_q == 0) ? 1 : longint'(row_count_q);
    first    = longint'(start_frame_q);
    last     = first + span - 1;
    if (last > 1023) last = 1023;

    // Count the frame boundaries crossed; the time left stays exact.
    remaining = longint'(ticks_left_q) - longint'(ticks);
    skip = 0;
    boundary = 1'b0;
    if (remaining <= 0) begin
      passed = (-remaining) / duration + 1;
      remaining += passed * duration;
      skip = (passed > 1024) ? 1024 : passed;
      boundary = 1'b1;
    end
    ticks_left_q = remaining[31:0];

    // Move the frame in the play mode; loops jump to the other end.
    frame = longint'(frame_q);
    if (boundary) begin
      case (play_mode_q)
        MODE_CLAMP_FWD: begin
          frame += skip;
          if (frame > last) frame = last;
        end
        MODE_LOOP_FWD: begin
          frame += skip;
          if (frame > last) frame = first;
        end
        MODE_CLAMP_BWD: begin
          frame -= skip;
          if (frame < first) frame = first;
        end
        default: begin
          frame -= skip;
          if (frame < first) frame = last;
        end
      endcase
      if (frame < 0) frame = 0;
      if (frame > 1023) frame = 1023;
    end
    frame_q = frame[9:0];

    width  = longint'(sheet_size_q[15:0]) / cols;
    height = longint'(sheet_size_q[31:16]) / rows;
    r.rect_x         = 17'(longint'(sheet_origin_q[15:0]) + (frame % cols) * width);
    r.rect_y         = 17'(longint'(sheet_origin_q[31:16]) + (frame / cols) * height);
    r.frame_width    = width[15:0];
    r.frame_height   = height[15:0];
    r.shown_frame    = frame[9:0];
    r.frame_advanced = boundary;
    return r;
  endfunction

  function automatic void report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  // Register write; valid drops before the next one is offered.
  task automatic write_reg(cfg_idx_t index, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request, sometimes after an idle burst, and log its result.
  task automatic send_ticks(logic [15:0] ticks, bit has_want, frame_rect_t want);
    frame_rect_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ticks;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = step_frame(ticks);
    pending_frames.push_back(has_want ? want : predicted);
  endtask

  // Stop sending and wait until every outstanding result is back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random register value: zero, all ones, any value, or a typical one.
  function automatic logic [31:0] pick_field(logic [31:0] full, logic [31:0] typical);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return full;
      2: return $urandom & full;
      default: return $urandom_range(1, typical);
    endcase
  endfunction

  function automatic void plan_write(cfg_idx_t index, logic [31:0] data);
    plan_row_t row;
    row.is_write = 1'b1;
    row.index    = index;
    row.data     = data;
    row.has_want = 1'b0;
    row.want     = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_ticks(logic [15:0] ticks, bit has_want, frame_rect_t want);
    plan_row_t row;
    row.is_write = 1'b0;
    row.index    = CFG_PLAY_MODE;
    row.data     = {16'd0, ticks};
    row.has_want = has_want;
    row.want     = want;
    plan.push_back(row);
  endfunction

  // Result checker.
  always @(posedge clk) begin
    frame_rect_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.rect_x         = m_axis_tdata[16:0];
      got.rect_y         = m_axis_tdata[33:17];
      got.frame_width    = m_axis_tdata[49:34];
      got.frame_height   = m_axis_tdata[65:50];
      got.shown_frame    = m_axis_tdata[75:66];
      got.frame_advanced = m_axis_tdata[76];
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %p", got));
      end else begin
        want = pending_frames.pop_front();
        if (got.rect_x != want.rect_x || got.rect_y != want.rect_y ||
            got.frame_width != want.frame_width ||
            got.frame_height != want.frame_height ||
            got.shown_frame != want.shown_frame ||
            got.frame_advanced != want.frame_advanced)
          report_mismatch($sformatf("expected %p, got %p", want, got));
      end
    end
  end

  // Result side: random stall bursts, and one long hold when asked.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 400;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin
    frame_rect_t none;
    frame_rect_t origin_only;
    frame_rect_t saturated;
    plan_row_t row;
    bit last_was_write;
    longint span;
    logic [15:0] ticks;

    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_PLAY_MODE;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    reset_shadow();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed plan. After reset one frame is one tick long, so a zero
    // step already crosses a boundary and loops back to frame zero.
    none = '0;
    origin_only = '{rect_x: 17'd0, rect_y: 17'd0, frame_width: 16'd0,
                    frame_height: 16'd0, shown_frame: 10'd0, frame_advanced: 1'b1};
    saturated = '{rect_x: 17'd65535, rect_y: 17'd65535, frame_width: 16'd65535,
                  frame_height: 16'd65535, shown_frame: 10'd0, frame_advanced: 1'b0};
    plan_ticks(16'd0, 1'b1, origin_only);
    plan_ticks(16'hFFFF, 1'b1, origin_only);
    plan_write(CFG_SHEET_ORIGIN, 32'hFFFF_FFFF);
    plan_write(CFG_SHEET_SIZE, 32'hFFFF_FFFF);
    plan_ticks(16'd0, 1'b1, saturated);
    // Zero duration and counts, and a sequence running past the last index.
    plan_write(CFG_PLAY_MODE, {30'd0, MODE_CLAMP_FWD});
    plan_write(CFG_FRAME_DURATION, 32'd0);
    plan_write(CFG_START_FRAME, 32'd1000);
    plan_write(CFG_FRAME_COUNT, 32'd1024);
    plan_write(CFG_COLUMN_COUNT, 32'd0);
    plan_write(CFG_ROW_COUNT, 32'd0);
    plan_ticks(16'd1, 1'b0, none);
    plan_ticks(16'hFFFF, 1'b0, none);
    plan_write(CFG_PLAY_MODE, {30'd0, MODE_LOOP_FWD});
    plan_ticks(16'd3, 1'b0, none);
    plan_write(CFG_PLAY_MODE, {30'd0, MODE_CLAMP_BWD});
    plan_write(CFG_FRAME_DURATION, 32'd65535);
    plan_ticks(16'hFFFF, 1'b0, none);
    plan_ticks(16'd0, 1'b0, none);
    plan_write(CFG_PLAY_MODE, {30'd0, MODE_LOOP_BWD});
    plan_write(CFG_FRAME_DURATION, 32'd7);
    plan_write(CFG_START_FRAME, 32'd0);
    plan_write(CFG_FRAME_COUNT, 32'd2047);
    plan_write(CFG_COLUMN_COUNT, 32'd256);
    plan_write(CFG_ROW_COUNT, 32'd256);
    plan_write(CFG_SHEET_SIZE, 32'h1234_ABCD);
    plan_write(CFG_SHEET_ORIGIN, 32'd0);
    plan_ticks(16'd1, 1'b0, none);
    plan_ticks(16'd20, 1'b0, none);
    plan_ticks(16'hFFFF, 1'b0, none);
    // Frame left outside a short sequence, then stepped back into it.
    plan_write(CFG_START_FRAME, 32'd5);
    plan_write(CFG_FRAME_COUNT, 32'd3);
    plan_write(CFG_PLAY_MODE, {30'd0, MODE_CLAMP_FWD});
    plan_write(CFG_COLUMN_COUNT, 32'd3);
    plan_write(CFG_ROW_COUNT, 32'd4);
    plan_write(CFG_SHEET_SIZE, 32'h005A_0064);
    plan_write(CFG_SHEET_ORIGIN, 32'h0014_000A);
    plan_ticks(16'd0, 1'b0, none);
    plan_ticks(16'd8, 1'b0, none);
    plan_write(CFG_PLAY_MODE, {30'd0, MODE_LOOP_BWD});
    plan_ticks(16'd8, 1'b0, none);
    plan_ticks(16'd8, 1'b0, none);
    plan_ticks(16'd8, 1'b0, none);
    plan_write(CFG_FRAME_COUNT, 32'd0);
    plan_write(CFG_PLAY_MODE, {30'd0, MODE_LOOP_FWD});
    plan_ticks(16'd8, 1'b0, none);
    plan_ticks(16'd8, 1'b0, none);

    // Writes wait until the block has returned every result.
    last_was_write = 1'b1;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_write) begin
        if (!last_was_write) drain();
        write_reg(row.index, row.data);
      end else begin
        send_ticks(row.data[15:0], row.has_want, row.want);
      end
      last_was_write = row.is_write;
    end

    // Random phases: new settings, then a run of steps.
    for (int phase = 0; phase < 12; phase++) begin
      drain();
      calm = (phase == 11);
      write_reg(CFG_PLAY_MODE, $urandom_range(0, 3));
      write_reg(CFG_FRAME_DURATION, pick_field(32'hFFFF, 12));
      write_reg(CFG_START_FRAME, pick_field(32'h3FF, 1023));
      write_reg(CFG_FRAME_COUNT, pick_field(32'h7FF, 8));
      write_reg(CFG_COLUMN_COUNT, pick_field(32'h1FF, 16));
      write_reg(CFG_ROW_COUNT, pick_field(32'h1FF, 16));
      write_reg(CFG_SHEET_ORIGIN, pick_field(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      write_reg(CFG_SHEET_SIZE, pick_field(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // Long hold on the result side while requests keep coming.
      if (phase == 3 || phase == 8) hold_request = 1'b1;
      span = (frame_duration_q == 0) ? 1 : longint'(frame_duration_q);
      for (int n = 0; n < 38; n++) begin
        case ($urandom_range(0, 9))
          0: ticks = 16'd0;
          1: ticks = 16'hFFFF;
          2: ticks = 16'($urandom);
          default: ticks = (3 * span > 65535) ? 16'($urandom)
                                              : 16'($urandom_range(0, 32'(3 * span)));
        endcase
        send_ticks(ticks, 1'b0, none);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("sprite_sheet_frame_sequencer_test: clean");
    end else begin
      $display("sprite_sheet_frame_sequencer_test: errors");
    end
    $finish;
  end

endmodule
